[sv/lphs_pkg.sv]
// lphs_pkg: shared types, constants and the home slot hash for the linear probe hash set
// no dependencies; imported by lphs_ctrl, lphs_dp and linear_probe_hash_set

package lphs_pkg;

	// table geometry, depth must be a power of two
	localparam int unsigned TABLE_DEPTH = 65536;
	localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
	localparam int unsigned CNT_W       = 17;
	localparam int unsigned SLOT_W      = 16;
	localparam int unsigned VAL_W       = 32;

	localparam logic [VAL_W-1:0]  HASH_MULT    = 32'h9E37_79B1;
	localparam logic [SLOT_W-1:0] HASH_MULT_LO = HASH_MULT[SLOT_W-1:0];

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

	typedef enum logic [0:0] {
		OP_INSERT = 1'b0,
		OP_READ   = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		RES_NEW     = 2'd0,
		RES_PRESENT = 2'd1,
		RES_FULL    = 2'd2,
		RES_READ    = 2'd3
	} res_kind_t;

	typedef struct packed {
		logic              op;
		logic [VAL_W-1:0]  value;
		logic [SLOT_W-1:0] slot;
	} in_item_t;

	typedef struct packed {
		logic              is_new;
		logic              already_present;
		logic              table_full;
		logic [SLOT_W-1:0] placed_slot;
		logic [CNT_W-1:0]  distinct_count;
		logic              slot_used;
		logic [VAL_W-1:0]  slot_value;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic      clr_step;
		logic      load_in;
		logic      rd_en;
		logic      adv;
		logic      wr_new;
		logic      load_res;
		res_kind_t res_kind;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic op_read;
		logic slot_used;
		logic match;
		logic probe_last;
	} stat_t;

	// only the low slot bits of the 32-bit product reach the index
	function automatic logic [IDX_W-1:0] home_slot(input logic [VAL_W-1:0] v);
		logic [SLOT_W-1:0] prod;
		prod = SLOT_W'(v[SLOT_W-1:0] * HASH_MULT_LO);
		return prod[IDX_W-1:0];
	endfunction

endpackage

[sv/lphs_ctrl.sv]
// lphs_ctrl: state machine for clearing, probing and result hand-off
// depends on lphs_pkg

module lphs_ctrl import lphs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	output logic  out_valid,
	input  logic  out_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_CHECK,
		ST_DONE
	} state_t;

	state_t    state_q, state_d;
	res_kind_t kind_q, kind_d;
	logic      out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d      = state_q;
		kind_d       = kind_q;
		cmd          = '0;
		cmd.res_kind = kind_q;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_CHECK;
			end
			ST_CHECK: begin
				if (stat.op_read) begin
					kind_d  = RES_READ;
					state_d = ST_DONE;
				end else if (!stat.slot_used) begin
					cmd.wr_new = 1'b1;
					kind_d     = RES_NEW;
					state_d    = ST_DONE;
				end else if (stat.match) begin
					kind_d  = RES_PRESENT;
					state_d = ST_DONE;
				end else if (stat.probe_last) begin
					kind_d  = RES_FULL;
					state_d = ST_DONE;
				end else begin
					cmd.adv = 1'b1;
					state_d = ST_READ;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_res = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			kind_q      <= RES_NEW;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
			if (cmd.load_res) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[sv/lphs_dp.sv]
// lphs_dp: slot memory, probe index, counters and result register
// depends on lphs_pkg

module lphs_dp import lphs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  in_item,
	input  cmd_t      cmd,
	output stat_t     stat,
	output out_item_t out_item
);

	// each word holds the used flag above the stored value
	logic [VAL_W:0] mem [TABLE_DEPTH];

	logic [IDX_W-1:0] clr_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] probe_q;
	logic             op_q;
	logic             in_range_q;
	logic [VAL_W-1:0] value_q;
	logic [VAL_W:0]   rdata_q;
	logic [CNT_W-1:0] count_q;
	out_item_t        res_q;
	out_item_t        res_d;

	logic             we;
	logic [IDX_W-1:0] waddr;
	logic [VAL_W:0]   wdata;
	logic             rd_used;

	assign we    = cmd.clr_step | cmd.wr_new;
	assign waddr = cmd.clr_step ? clr_q : idx_q;
	assign wdata = cmd.clr_step ? '0 : {1'b1, value_q};

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[idx_q];
		end
	end

	// clearing sweep and distinct count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			count_q <= '0;
		end else begin
			if (cmd.clr_step) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.wr_new && (count_q < CNT_W'(TABLE_DEPTH))) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q       <= in_item.op;
			value_q    <= in_item.value;
			in_range_q <= ({1'b0, in_item.slot} < (SLOT_W + 1)'(TABLE_DEPTH));
			probe_q    <= '0;
			if (in_item.op == OP_READ) begin
				idx_q <= in_item.slot[IDX_W-1:0];
			end else begin
				idx_q <= home_slot(in_item.value);
			end
		end else if (cmd.adv) begin
			idx_q   <= idx_q + 1'b1;
			probe_q <= probe_q + 1'b1;
		end
	end

	assign rd_used = rdata_q[VAL_W] & in_range_q;

	always_comb begin
		res_d                = '0;
		res_d.distinct_count = count_q;
		case (cmd.res_kind)
			RES_NEW: begin
				res_d.is_new      = 1'b1;
				res_d.placed_slot = SLOT_W'(idx_q);
			end
			RES_PRESENT: begin
				res_d.already_present = 1'b1;
				res_d.placed_slot     = SLOT_W'(idx_q);
			end
			RES_FULL: begin
				res_d.table_full = 1'b1;
			end
			default: begin
				res_d.slot_used  = rd_used;
				res_d.slot_value = rd_used ? rdata_q[VAL_W-1:0] : '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_res) begin
			res_q <= res_d;
		end
	end

	assign out_item = res_q;

	assign stat.clr_last   = (clr_q == IDX_LAST);
	assign stat.op_read    = (op_q == OP_READ);
	assign stat.slot_used  = rdata_q[VAL_W];
	assign stat.match      = (rdata_q[VAL_W-1:0] == value_q);
	assign stat.probe_last = (probe_q == IDX_LAST);

endmodule

[sv/linear_probe_hash_set.sv]
// linear_probe_hash_set: top level joining the controller and the datapath
// depends on lphs_pkg, lphs_ctrl and lphs_dp
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------------
//   in      | in_valid / in_ready  | in_item  (op, value, slot)
//   out     | out_valid/ out_ready | out_item (is_new .. slot_value)
//
// an insert is taken in ST_IDLE, then each probe is a registered read of the slot
// memory in ST_READ followed by the compare in ST_CHECK, until ST_DONE hands off
// the result; a slot read does one read and compare, and a full table walks all slots
// reset: after arst_n is released one slot is cleared per cycle, and in_ready stays
// low until all TABLE_DEPTH (65536) slots are cleared
// stalls: a result waiting in the output register does not block the next input
// transfer; only the hand-off of the following result waits for out_ready

module linear_probe_hash_set import lphs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	// command and status between the two halves
	cmd_t  cmd;
	stat_t stat;

	// sequencing: clear sweep, probe loop, result hand-off
	lphs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// slot memory, probe index, distinct count and result register
	lphs_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (in_item),
		.cmd      (cmd),
		.stat     (stat),
		.out_item (out_item)
	);

endmodule
